// ===== rtl/core/ata_pio_sector_sequencer_unit_macros.svh =====
// Assertion macros used by the sequencer back end (apss_back).
`ifndef ATA_PIO_SECTOR_SEQUENCER_UNIT_MACROS_SVH
`define ATA_PIO_SECTOR_SEQUENCER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define APSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("sequencer assertion failed");
`define APSS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("sequencer assertion failed");
`else
`define APSS_ASSERT(lbl, prop)
`define APSS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/apss_pkg.sv =====
// Shared types and constants of the ATA PIO sector sequencer.
package apss_pkg;
	localparam int MaxSectorsDefault = 8;
	localparam int WordsPerSector    = 256;
	localparam int PollLimitReset    = 200000;
	localparam int BasePortReset     = 'h1F0;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STAT  = 2'd1;
	localparam logic [1:0] CMD_RDW   = 2'd2;
	localparam logic [1:0] CMD_WRW   = 2'd3;

	localparam logic [2:0] KIND_PWR   = 3'd0;
	localparam logic [2:0] KIND_PRD   = 3'd1;
	localparam logic [2:0] KIND_WORD  = 3'd2;
	localparam logic [2:0] KIND_FETCH = 3'd3;
	localparam logic [2:0] KIND_DONE  = 3'd4;

	localparam logic [1:0] OUT_OK   = 2'd0;
	localparam logic [1:0] OUT_ERR  = 2'd1;
	localparam logic [1:0] OUT_TOUT = 2'd2;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_TF   = 2'd1;
	localparam logic [1:0] OP_RDW  = 2'd2;
	localparam logic [1:0] OP_WRW  = 2'd3;

	localparam logic [1:0] TAIL_POLL  = 2'd0;
	localparam logic [1:0] TAIL_DONE  = 2'd1;
	localparam logic [1:0] TAIL_RDREQ = 2'd2;
	localparam logic [1:0] TAIL_FETCH = 2'd3;

	localparam logic [2:0] TF_STEPS = 3'd6;

	localparam logic [1:0] CFG_POLL_IDX   = 2'd0;
	localparam logic [1:0] CFG_BASE_IDX   = 2'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  tail;
		logic [27:0] lba;
		logic        writing;
		logic [15:0] value;
		logic [10:0] idx;
		logic [1:0]  outcome;
	} job_t;
endpackage

// ===== rtl/core/apss_front.sv =====
// Front end: accepts words, runs the request state machine, queues jobs.
module apss_front #(
	parameter int MAX_SECTORS = apss_pkg::MaxSectorsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [27:0]        start_lba,
	input  logic [3:0]         sector_total,
	input  logic               write_dir,
	input  logic [7:0]         status_byte,
	input  logic [15:0]        data_word,
	input  logic [19:0]        poll_limit,
	input  logic               q_full,
	output logic               q_push,
	output apss_pkg::job_t     q_job
);
	import apss_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_PRE  = 3'd1;
	localparam logic [2:0] PH_DRQ  = 3'd2;
	localparam logic [2:0] PH_RD   = 3'd3;
	localparam logic [2:0] PH_WR   = 3'd4;
	localparam logic [2:0] PH_POST = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [27:0] lba_q, lba_d;
	logic [3:0]  left_q, left_d;
	logic [2:0]  off_q, off_d;
	logic [7:0]  wc_q, wc_d;
	logic [19:0] polls_q, polls_d;
	logic        wr_q, wr_d;
	logic        fire;
	logic        emit;
	job_t        job;
	logic [3:0]  cnt;
	logic        ok;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign cnt      = (32'(sector_total) > MAX_SECTORS) ? 4'(MAX_SECTORS) : sector_total;
	assign ok       = !status_byte[7] && ((phase_q != PH_DRQ) || status_byte[3]);

	always_comb begin
		phase_d = phase_q;
		lba_d   = lba_q;
		left_d  = left_q;
		off_d   = off_q;
		wc_d    = wc_q;
		polls_d = polls_q;
		wr_d    = wr_q;
		emit    = 1'b0;
		job     = '0;
		job.lba     = lba_q;
		job.writing = wr_q;
		job.value   = data_word;
		case (cmd)
			CMD_START: begin
				if (phase_q == PH_IDLE) begin
					emit    = 1'b1;
					lba_d   = start_lba;
					wr_d    = write_dir;
					left_d  = cnt;
					off_d   = '0;
					wc_d    = '0;
					polls_d = '0;
					if (cnt == 4'd0) begin
						job.tail = TAIL_DONE;
					end else if (poll_limit == '0) begin
						job.tail    = TAIL_DONE;
						job.outcome = OUT_TOUT;
					end else begin
						job.tail = TAIL_POLL;
						polls_d  = 20'd1;
						phase_d  = PH_PRE;
					end
				end
			end
			CMD_STAT: begin
				if (phase_q == PH_PRE || phase_q == PH_DRQ || phase_q == PH_POST) begin
					emit = 1'b1;
					if (ok) begin
						case (phase_q)
							PH_PRE: begin
								job.op = OP_TF;
								if (poll_limit == '0) begin
									job.tail    = TAIL_DONE;
									job.outcome = OUT_TOUT;
									phase_d     = PH_IDLE;
								end else begin
									job.tail = TAIL_POLL;
									polls_d  = 20'd1;
									phase_d  = PH_DRQ;
								end
							end
							PH_DRQ: begin
								wc_d = '0;
								if (wr_q) begin
									phase_d  = PH_WR;
									job.tail = TAIL_FETCH;
									job.idx  = {off_q, 8'h00};
								end else begin
									phase_d  = PH_RD;
									job.tail = TAIL_RDREQ;
								end
							end
							default: begin
								left_d = left_q - 4'd1;
								lba_d  = lba_q + 28'd1;
								off_d  = off_q + 3'd1;
								if (left_q == 4'd1) begin
									job.tail = TAIL_DONE;
									phase_d  = PH_IDLE;
								end else if (poll_limit == '0) begin
									job.tail    = TAIL_DONE;
									job.outcome = OUT_TOUT;
									phase_d     = PH_IDLE;
								end else begin
									job.tail = TAIL_POLL;
									polls_d  = 20'd1;
									phase_d  = PH_PRE;
								end
							end
						endcase
					end else if (status_byte[0]) begin
						job.tail    = TAIL_DONE;
						job.outcome = OUT_ERR;
						phase_d     = PH_IDLE;
					end else if (polls_q >= poll_limit) begin
						job.tail    = TAIL_DONE;
						job.outcome = OUT_TOUT;
						phase_d     = PH_IDLE;
					end else begin
						job.tail = TAIL_POLL;
						polls_d  = polls_q + 20'd1;
					end
				end
			end
			default: begin
				if ((cmd == CMD_RDW && phase_q == PH_RD) ||
				    (cmd == CMD_WRW && phase_q == PH_WR)) begin
					emit   = 1'b1;
					job.op = (cmd == CMD_RDW) ? OP_RDW : OP_WRW;
					job.idx = {off_q, wc_q};
					if (wc_q == 8'(WordsPerSector - 1)) begin
						if (poll_limit == '0) begin
							job.tail    = TAIL_DONE;
							job.outcome = OUT_TOUT;
							phase_d     = PH_IDLE;
						end else begin
							job.tail = TAIL_POLL;
							polls_d  = 20'd1;
							phase_d  = PH_POST;
						end
					end else begin
						wc_d = wc_q + 8'd1;
						if (cmd == CMD_RDW) begin
							job.tail = TAIL_RDREQ;
						end else begin
							job.tail = TAIL_FETCH;
							job.idx  = {off_q, wc_q + 8'd1};
						end
					end
				end
			end
		endcase
	end

	assign q_push = fire && emit;
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lba_q   <= '0;
			left_q  <= '0;
			off_q   <= '0;
			wc_q    <= '0;
			polls_q <= '0;
			wr_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			lba_q   <= lba_d;
			left_q  <= left_d;
			off_q   <= off_d;
			wc_q    <= wc_d;
			polls_q <= polls_d;
			wr_q    <= wr_d;
		end
	end
endmodule

// ===== rtl/core/apss_fifo.sv =====
// Job queue between the front end and the result generator.
module apss_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  apss_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output apss_pkg::job_t head
);
	import apss_pkg::*;

	job_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

// ===== rtl/core/apss_back.sv =====
// Back end: expands queued jobs into result words.
`include "ata_pio_sector_sequencer_unit_macros.svh"
module apss_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  apss_pkg::job_t job,
	output logic           q_pop,
	input  logic [15:0]    base_port,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     kind,
	output logic [15:0]    port_addr,
	output logic           word_access,
	output logic [15:0]    port_value,
	output logic [10:0]    buffer_index,
	output logic [1:0]     outcome,
	output logic           last
);
	import apss_pkg::*;

	logic [2:0] step_q;
	logic       is_tail;
	logic       take;

	assign out_valid = !q_empty;
	assign take      = out_valid && out_ready;
	assign is_tail   = (job.op == OP_NONE) ||
	                   (job.op == OP_TF && step_q == TF_STEPS) ||
	                   ((job.op == OP_RDW || job.op == OP_WRW) && step_q == 3'd1);
	assign q_pop     = take && is_tail;
	assign last      = is_tail;

	always_comb begin
		kind         = KIND_PWR;
		port_addr    = '0;
		word_access  = 1'b0;
		port_value   = '0;
		buffer_index = '0;
		outcome      = OUT_OK;
		if (is_tail) begin
			case (job.tail)
				TAIL_POLL: begin
					kind      = KIND_PRD;
					port_addr = base_port + 16'd7;
				end
				TAIL_DONE: begin
					kind    = KIND_DONE;
					outcome = job.outcome;
				end
				TAIL_RDREQ: begin
					kind        = KIND_PRD;
					port_addr   = base_port;
					word_access = 1'b1;
				end
				default: begin
					kind         = KIND_FETCH;
					buffer_index = job.idx;
				end
			endcase
		end else if (job.op == OP_RDW) begin
			kind         = KIND_WORD;
			port_value   = job.value;
			buffer_index = job.idx;
		end else if (job.op == OP_WRW) begin
			port_addr   = base_port;
			word_access = 1'b1;
			port_value  = job.value;
		end else begin
			case (step_q)
				3'd0: begin
					port_addr  = base_port + 16'd6;
					port_value = {8'h00, 4'hE, job.lba[27:24]};
				end
				3'd1: begin
					port_addr  = base_port + 16'd2;
					port_value = 16'd1;
				end
				3'd2: begin
					port_addr  = base_port + 16'd3;
					port_value = {8'h00, job.lba[7:0]};
				end
				3'd3: begin
					port_addr  = base_port + 16'd4;
					port_value = {8'h00, job.lba[15:8]};
				end
				3'd4: begin
					port_addr  = base_port + 16'd5;
					port_value = {8'h00, job.lba[23:16]};
				end
				default: begin
					port_addr  = base_port + 16'd7;
					port_value = job.writing ? 16'h0030 : 16'h0020;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (take) begin
			step_q <= is_tail ? 3'd0 : step_q + 3'd1;
		end
	end

	`APSS_ASSERT(a_idle_step, q_empty |-> (step_q == 3'd0))
	`APSS_ASSERT(a_step_range, (!q_empty && job.op != OP_TF) |-> (step_q <= 3'd1))
	`APSS_ASSERT_NEXT(a_job_holds, take && !is_tail, out_valid && step_q != 3'd0)
endmodule

// ===== rtl/core/ata_pio_sector_sequencer_unit.sv =====
// Top level of the ATA PIO LBA28 sector sequencer.
//  channel | direction | words
//  in      | in        | cmd, start_lba, sector_total, write_dir, status_byte, data_word
//  out     | out       | kind, port_addr, word_access, port_value, buffer_index, outcome, last
//  cfg     | in        | cfg_index, cfg_data (0 poll_limit, 1 base_port)
// One input word is taken per cycle while the four-entry job queue has room.
// Results leave one per cycle while out_ready is high; a taskfile job yields seven results, others one or two.
// Reset clears the request state and queue; registers return to 200000 and 0x1F0.
// A stalled output fills the queue and then holds in_ready low.
module ata_pio_sector_sequencer_unit #(
	parameter int MAX_SECTORS = apss_pkg::MaxSectorsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [27:0] start_lba,
	input  logic [3:0]  sector_total,
	input  logic        write_dir,
	input  logic [7:0]  status_byte,
	input  logic [15:0] data_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [15:0] port_addr,
	output logic        word_access,
	output logic [15:0] port_value,
	output logic [10:0] buffer_index,
	output logic [1:0]  outcome,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import apss_pkg::*;

	logic [19:0] poll_limit_q;
	logic [15:0] base_port_q;
	logic        q_full, q_empty, q_push, q_pop;
	job_t        push_job, head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= 20'(PollLimitReset);
			base_port_q  <= 16'(BasePortReset);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_POLL_IDX) poll_limit_q <= cfg_data;
			if (cfg_index == CFG_BASE_IDX) base_port_q <= cfg_data[15:0];
		end
	end

	apss_front #(.MAX_SECTORS(MAX_SECTORS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .start_lba, .sector_total,
		.write_dir, .status_byte, .data_word, .poll_limit(poll_limit_q),
		.q_full, .q_push, .q_job(push_job)
	);

	apss_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .push_job, .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(head_job)
	);

	apss_back u_back (
		.clk, .arst_n, .q_empty, .job(head_job), .q_pop, .base_port(base_port_q),
		.out_valid, .out_ready, .kind, .port_addr, .word_access, .port_value,
		.buffer_index, .outcome, .last
	);
endmodule

// ===== dv/ata_pio_sector_sequencer_unit_tb.sv =====
// Self-checking testbench for the ATA PIO LBA28 sector sequencer.
`timescale 1ns / 100ps

module ata_pio_sector_sequencer_unit_tb;
	import apss_pkg::*;

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_WAIT_PRE  = 3'd1;
	localparam logic [2:0] PH_WAIT_DRQ  = 3'd2;
	localparam logic [2:0] PH_XFER_RD   = 3'd3;
	localparam logic [2:0] PH_XFER_WR   = 3'd4;
	localparam logic [2:0] PH_WAIT_POST = 3'd5;

	localparam logic [7:0] ST_BSY = 8'h80;
	localparam logic [7:0] ST_DRQ = 8'h08;
	localparam logic [7:0] ST_ERR = 8'h01;

	localparam logic [3:0] REG_DEVHEAD = 4'd6;
	localparam logic [3:0] REG_COUNT   = 4'd2;
	localparam logic [3:0] REG_LBA_LO  = 4'd3;
	localparam logic [3:0] REG_LBA_MID = 4'd4;
	localparam logic [3:0] REG_LBA_HI  = 4'd5;
	localparam logic [3:0] REG_CMDSTAT = 4'd7;

	localparam logic [7:0] ATA_READ  = 8'h20;
	localparam logic [7:0] ATA_WRITE = 8'h30;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] port_addr;
		logic        word_access;
		logic [15:0] port_value;
		logic [10:0] buffer_index;
		logic [1:0]  outcome;
		logic        last;
	} port_access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [27:0] start_lba = '0;
	logic [3:0] sector_total = '0;
	logic write_dir = 1'b0;
	logic [7:0] status_byte = '0;
	logic [15:0] data_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [15:0] port_addr;
	logic word_access;
	logic [15:0] port_value;
	logic [10:0] buffer_index;
	logic [1:0] outcome;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	ata_pio_sector_sequencer_unit dut (.*);

	initial forever #5 clk = ~clk;

	// predicted sequencer state
	logic [19:0] poll_lim;
	logic [15:0] base_addr;
	logic [2:0]  ph;
	logic [27:0] cur_lba;
	logic [3:0]  secs_left;
	logic [2:0]  sec_off;
	logic [7:0]  word_cnt;
	logic [19:0] polls;
	logic        wr_mode;

	port_access_t expected_q[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_start = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int done_seen[3] = '{0, 0, 0};
	bit wind_down = 0;

	task automatic push_access(logic [2:0] k, logic [15:0] a, logic w, logic [15:0] v,
			logic [10:0] i, logic [1:0] o);
		expected_q.push_back('{k, a, w, v, i, o, 1'b0});
	endtask

	task automatic end_request(logic [1:0] o);
		ph = PH_IDLE;
		push_access(KIND_DONE, '0, 1'b0, '0, '0, o);
	endtask

	task automatic start_wait(logic [2:0] nxt);
		if (poll_lim == '0) begin
			end_request(OUT_TOUT);
		end else begin
			polls = 20'd1;
			ph = nxt;
			push_access(KIND_PRD, base_addr + REG_CMDSTAT, 1'b0, '0, '0, OUT_OK);
		end
	endtask

	task automatic write_reg(logic [3:0] off, logic [7:0] v);
		push_access(KIND_PWR, base_addr + off, 1'b0, {8'h00, v}, '0, OUT_OK);
	endtask

	task automatic wait_satisfied();
		if (ph == PH_WAIT_PRE) begin
			write_reg(REG_DEVHEAD, 8'hE0 | {4'h0, cur_lba[27:24]});
			write_reg(REG_COUNT, 8'd1);
			write_reg(REG_LBA_LO, cur_lba[7:0]);
			write_reg(REG_LBA_MID, cur_lba[15:8]);
			write_reg(REG_LBA_HI, cur_lba[23:16]);
			write_reg(REG_CMDSTAT, wr_mode ? ATA_WRITE : ATA_READ);
			start_wait(PH_WAIT_DRQ);
		end else if (ph == PH_WAIT_DRQ) begin
			word_cnt = '0;
			if (wr_mode) begin
				ph = PH_XFER_WR;
				push_access(KIND_FETCH, '0, 1'b0, '0, {sec_off, word_cnt}, OUT_OK);
			end else begin
				ph = PH_XFER_RD;
				push_access(KIND_PRD, base_addr, 1'b1, '0, '0, OUT_OK);
			end
		end else begin
			secs_left = secs_left - 1'b1;
			cur_lba = cur_lba + 1'b1;
			sec_off = sec_off + 1'b1;
			if (secs_left == '0)
				end_request(OUT_OK);
			else
				start_wait(PH_WAIT_PRE);
		end
	endtask

	task automatic predict_sequencer(logic [1:0] c, logic [27:0] lba, logic [3:0] tot,
			logic dir, logic [7:0] st, logic [15:0] dw);
		int n0;
		bit met;
		n0 = expected_q.size();
		case (c)
			CMD_START: if (ph == PH_IDLE) begin
				cur_lba = lba;
				wr_mode = dir;
				secs_left = (tot > MaxSectorsDefault) ? 4'(MaxSectorsDefault) : tot;
				sec_off = '0;
				word_cnt = '0;
				polls = '0;
				if (secs_left == '0)
					end_request(OUT_OK);
				else
					start_wait(PH_WAIT_PRE);
			end
			CMD_STAT: if (ph == PH_WAIT_PRE || ph == PH_WAIT_DRQ || ph == PH_WAIT_POST) begin
				met = (st & ST_BSY) == '0;
				if (ph == PH_WAIT_DRQ)
					met = met && ((st & ST_DRQ) != '0);
				if (met) begin
					wait_satisfied();
				end else if ((st & ST_ERR) != '0) begin
					end_request(OUT_ERR);
				end else if (polls >= poll_lim) begin
					end_request(OUT_TOUT);
				end else begin
					polls = polls + 1'b1;
					push_access(KIND_PRD, base_addr + REG_CMDSTAT, 1'b0, '0, '0, OUT_OK);
				end
			end
			CMD_RDW: if (ph == PH_XFER_RD) begin
				push_access(KIND_WORD, '0, 1'b0, dw, {sec_off, word_cnt}, OUT_OK);
				if (word_cnt == 8'hFF) begin
					start_wait(PH_WAIT_POST);
				end else begin
					word_cnt = word_cnt + 1'b1;
					push_access(KIND_PRD, base_addr, 1'b1, '0, '0, OUT_OK);
				end
			end
			default: if (ph == PH_XFER_WR) begin
				push_access(KIND_PWR, base_addr, 1'b1, dw, '0, OUT_OK);
				if (word_cnt == 8'hFF) begin
					start_wait(PH_WAIT_POST);
				end else begin
					word_cnt = word_cnt + 1'b1;
					push_access(KIND_FETCH, '0, 1'b0, '0, {sec_off, word_cnt}, OUT_OK);
				end
			end
		endcase
		if (expected_q.size() > n0)
			expected_q[expected_q.size() - 1].last = 1'b1;
	endtask

	// call at a rising edge
	task automatic send_word(logic [1:0] c, logic [27:0] lba, logic [3:0] tot, logic dir,
			logic [7:0] st, logic [15:0] dw);
		cmd <= c;
		start_lba <= lba;
		sector_total <= tot;
		write_dir <= dir;
		status_byte <= st;
		data_word <= dw;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_sequencer(c, lba, tot, dir, st, dw);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_random_word();
		logic [1:0] c;
		logic [27:0] lba;
		logic [3:0] tot;
		logic [7:0] st;
		int roll;
		c = 2'($urandom_range(3));
		lba = 28'($urandom);
		tot = 4'($urandom_range(15));
		st = 8'($urandom_range(255));
		roll = $urandom_range(99);
		if (wind_down || $urandom_range(99) >= 6) begin
			case (ph)
				PH_IDLE: begin
					c = CMD_START;
					if ($urandom_range(7) == 0)
						lba = $urandom_range(1) ? 28'hFFFFFFF : 28'h0;
					if ($urandom_range(99) < 75)
						tot = 4'($urandom_range(2, 1));
				end
				PH_XFER_RD: c = CMD_RDW;
				PH_XFER_WR: c = CMD_WRW;
				default: begin
					c = CMD_STAT;
					if (wind_down || roll >= 93)
						st = st | ST_BSY | ST_ERR;
					else if (roll < 80)
						st = st & ~ST_BSY;
					else if ($urandom_range(1) != 0)
						st = (st | ST_BSY) & ~ST_ERR;
					else
						st = st & ~(ST_BSY | ST_DRQ | ST_ERR);
				end
			endcase
		end
		// keep random traffic out of the data phases
		if (ph == PH_WAIT_DRQ)
			st = st & ~ST_DRQ;
		send_word(c, lba, tot, 1'($urandom_range(1)), st, 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic settle();
		wind_down = 1;
		while (ph != PH_IDLE)
			send_random_word();
		wind_down = 0;
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [1:0] idx, logic [19:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_POLL_IDX)
			poll_lim = val;
		else if (idx == CFG_BASE_IDX)
			base_addr = val[15:0];
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(CMD_START, 28'h1234567, 4'd0, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_RDW, '0, '0, 1'b0, 8'h00, 16'hFFFF);
		send_word(CMD_WRW, '0, '0, 1'b0, 8'h00, 16'hFFFF);
		send_word(CMD_START, 28'hFFFFFFF, 4'd15, 1'b1, 8'h00, 16'h0000);
		send_word(CMD_START, 28'h0000000, 4'd1, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_RDW, '0, '0, 1'b0, 8'h00, 16'h1111);
		send_word(CMD_STAT, '0, '0, 1'b0, ST_BSY, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h41, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h09, 16'h0000);
		send_word(CMD_RDW, '0, '0, 1'b0, 8'h00, 16'h2222);
		send_word(CMD_WRW, '0, '0, 1'b0, 8'h00, 16'hFFFF);
		send_word(CMD_WRW, '0, '0, 1'b0, 8'h00, 16'h0000);
		settle();
		send_word(CMD_START, 28'h0000000, 4'd2, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h7F, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h81, 16'h0000);
		settle();
	endtask

	task automatic test_poll_limits();
		write_config(CFG_POLL_IDX, 20'd0);
		send_word(CMD_START, 28'h0ABCDEF, 4'd3, 1'b0, 8'h00, 16'h0000);
		settle();
		write_config(CFG_POLL_IDX, 20'd1);
		write_config(CFG_BASE_IDX, 20'h0FFFF);
		send_word(CMD_START, 28'h0ABCDEF, 4'd3, 1'b1, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'hF6, 16'h0000);
		settle();
		write_config(CFG_POLL_IDX, 20'hFFFFF);
		write_config(CFG_BASE_IDX, 20'hF0000);
	endtask

	task automatic test_random(int count, int idle, int stall, logic [19:0] lim,
			logic [19:0] base);
		write_config(CFG_POLL_IDX, lim);
		write_config(CFG_BASE_IDX, base);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count) send_random_word();
		settle();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		send_word(CMD_START, 28'hFFFFFFF, 4'd2, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h40, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h48, 16'h0000);
		hold_start = 1;
		repeat (256)
			send_word(CMD_RDW, '0, '0, 1'b0, 8'h00, 16'($urandom_range(16'hFFFF)));
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h00, 16'h0000);
		send_word(CMD_STAT, '0, '0, 1'b0, 8'h00, 16'h0000);
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = 300;
			hold_start = 0;
		end
		if (hold_left > 0)
			hold_left--;
		out_ready <= arst_n && hold_left == 0 && $urandom_range(99) >= stall_pct;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (kind == KIND_DONE && outcome <= OUT_TOUT)
				done_seen[outcome]++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d addr %h value %h", kind, port_addr,
						port_value);
			end else begin
				port_access_t want;
				port_access_t got;
				want = expected_q.pop_front();
				got = '{kind, port_addr, word_access, port_value, buffer_index, outcome, last};
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp k%0d a%h w%0d v%h i%0d o%0d l%0d, ",
							"got k%0d a%h w%0d v%h i%0d o%0d l%0d"},
							want.kind, want.port_addr, want.word_access, want.port_value,
							want.buffer_index, want.outcome, want.last,
							got.kind, got.port_addr, got.word_access, got.port_value,
							got.buffer_index, got.outcome, got.last);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		poll_lim = 20'(PollLimitReset);
		base_addr = 16'(BasePortReset);
		ph = PH_IDLE;
		cur_lba = '0;
		secs_left = '0;
		sec_off = '0;
		word_cnt = '0;
		polls = '0;
		wr_mode = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_poll_limits();
		test_random(20, 0, 0, 20'd200000, 20'h001F0);
		test_random(20, 46, 0, 20'd3, 20'h00000);
		test_random(20, 0, 46, 20'd1, 20'h0FFFF);
		test_random(20, 25, 25, 20'hFFFFF, 20'($urandom_range(16'hFFFF)));
		test_backpressure();
		$display("sent %0d input words, checked %0d results", items_sent, results_seen);
		$display("requests done: %0d ok, %0d device error, %0d poll timeout",
			done_seen[0], done_seen[1], done_seen[2]);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/apss_pkg.sv
rtl/core/apss_front.sv
rtl/core/apss_fifo.sv
rtl/core/apss_back.sv
rtl/core/ata_pio_sector_sequencer_unit.sv
dv/ata_pio_sector_sequencer_unit_tb.sv
